// ----- rtl/fdbvs_pkg.sv -----
// ----------------------------------------------------------------------------
// fdbvs_pkg
// Shared widths, strategy codes, register map and structs of the selector.
// ----------------------------------------------------------------------------
`default_nettype none

package fdbvs_pkg;

    localparam int VALUE_BITS  = 27;
    localparam int SUSP_BITS   = 16;
    localparam int SEL_BITS    = 10;
    localparam int ALT_BITS    = 2;
    localparam int STRAT_BITS  = 3;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 72;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    // variable strategies
    localparam logic [STRAT_BITS-1:0] VAR_NAIVE = 3'd0;
    localparam logic [STRAT_BITS-1:0] VAR_SIZE  = 3'd1;
    localparam logic [STRAT_BITS-1:0] VAR_WIDTH = 3'd2;
    localparam logic [STRAT_BITS-1:0] VAR_MIN   = 3'd3;
    localparam logic [STRAT_BITS-1:0] VAR_MAX   = 3'd4;
    localparam logic [STRAT_BITS-1:0] VAR_MOST  = 3'd5;

    // value strategies
    localparam logic [STRAT_BITS-1:0] VAL_MIN      = 3'd0;
    localparam logic [STRAT_BITS-1:0] VAL_MID      = 3'd1;
    localparam logic [STRAT_BITS-1:0] VAL_MAX      = 3'd2;
    localparam logic [STRAT_BITS-1:0] VAL_SPLIT_LO = 3'd3;
    localparam logic [STRAT_BITS-1:0] VAL_SPLIT_HI = 3'd4;

    localparam logic [ALT_BITS-1:0] ALT_ONE = 2'd1;
    localparam logic [ALT_BITS-1:0] ALT_TWO = 2'd2;

    localparam logic [VALUE_BITS-1:0] DOMAIN_SUP_RST = 27'd134217726;

    typedef enum logic [1:0] {
        REG_VAR_STRAT  = 2'd0,
        REG_VAL_STRAT  = 2'd1,
        REG_ASSIGN     = 2'd2,
        REG_DOMAIN_SUP = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [STRAT_BITS-1:0] var_strategy;
        logic [STRAT_BITS-1:0] val_strategy;
        logic                  assign_mode;
        logic [VALUE_BITS-1:0] domain_sup;
    } cfg_t;

    typedef struct packed {
        logic                  is_determined;
        logic [VALUE_BITS-1:0] dom_size;
        logic [VALUE_BITS-1:0] dom_width;
        logic [VALUE_BITS-1:0] dom_min;
        logic [VALUE_BITS-1:0] dom_max;
        logic [VALUE_BITS-1:0] dom_mid;
        logic [SUSP_BITS-1:0]  susp_count;
        logic                  last_item;
    } item_t;

    // best entry after the current item has been folded in
    typedef struct packed {
        logic                  have_best;
        logic [VALUE_BITS-1:0] best_min;
        logic [VALUE_BITS-1:0] best_mid;
        logic [VALUE_BITS-1:0] best_max;
    } best_t;

endpackage

`default_nettype wire

// ----- rtl/fdbvs_cfg.sv -----
// ----------------------------------------------------------------------------
// fdbvs_cfg
// APB register file: strategies, assign mode and upper domain bound.
// ----------------------------------------------------------------------------
`default_nettype none

module fdbvs_cfg import fdbvs_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_VAR_STRAT:  cfg_next.var_strategy = pwdata[STRAT_BITS-1:0];
                REG_VAL_STRAT:  cfg_next.val_strategy = pwdata[STRAT_BITS-1:0];
                REG_ASSIGN:     cfg_next.assign_mode  = pwdata[0];
                REG_DOMAIN_SUP: cfg_next.domain_sup   = pwdata[VALUE_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_VAR_STRAT:  prdata = PDATA_W'(cfg_reg.var_strategy);
            REG_VAL_STRAT:  prdata = PDATA_W'(cfg_reg.val_strategy);
            REG_ASSIGN:     prdata = PDATA_W'(cfg_reg.assign_mode);
            REG_DOMAIN_SUP: prdata = PDATA_W'(cfg_reg.domain_sup);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.var_strategy <= VAR_NAIVE;
            cfg_reg.val_strategy <= VAL_MIN;
            cfg_reg.assign_mode  <= 1'b0;
            cfg_reg.domain_sup   <= DOMAIN_SUP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/fdbvs_accum.sv -----
// ----------------------------------------------------------------------------
// fdbvs_accum
// Running best-entry search over the open descriptors of one vector.
// ----------------------------------------------------------------------------
`default_nettype none

module fdbvs_accum import fdbvs_pkg::*; #(
    parameter int MAX_VARS = 1024,
    localparam int CNT_W  = $clog2(MAX_VARS + 1),
    localparam int RANK_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire item_t             item,
    input  wire cfg_t              cfg,
    output best_t                  best,
    output logic [CNT_W-1:0]       open_count,
    output logic [RANK_W-1:0]      best_rank
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VARS);

    logic                  have_best_reg, have_best_next;
    logic [CNT_W-1:0]      open_count_reg, open_count_next;
    logic [VALUE_BITS-1:0] best_key_reg, best_key_next;
    logic [VALUE_BITS-1:0] best_size_reg, best_size_next;
    logic [SUSP_BITS-1:0]  best_susp_reg, best_susp_next;
    logic [RANK_W-1:0]     best_rank_reg, best_rank_next;
    logic [VALUE_BITS-1:0] best_min_reg, best_min_next;
    logic [VALUE_BITS-1:0] best_mid_reg, best_mid_next;
    logic [VALUE_BITS-1:0] best_max_reg, best_max_next;

    logic [STRAT_BITS-1:0] strat;
    logic                  open_ok;
    logic [VALUE_BITS-1:0] key;
    logic                  better;
    logic                  take;

    always_comb begin
        strat   = cfg.assign_mode ? VAR_NAIVE : cfg.var_strategy;
        open_ok = !item.is_determined && (open_count_reg < MAX_CNT);

        case (strat) inside
            VAR_SIZE, VAR_MOST: key = item.dom_size;
            VAR_WIDTH:          key = item.dom_width;
            VAR_MIN:            key = item.dom_min;
            VAR_MAX:            key = item.dom_max;
            default:            key = '0;
        endcase

        // strict compares: ties keep the entry scanned first
        case (strat) inside
            VAR_SIZE, VAR_WIDTH, VAR_MIN: better = key < best_key_reg;
            VAR_MAX:  better = key > best_key_reg;
            VAR_MOST: better = (item.susp_count > best_susp_reg) ||
                               ((item.susp_count == best_susp_reg) &&
                                (item.dom_size < best_size_reg));
            default:  better = 1'b0;
        endcase

        take = open_ok && (!have_best_reg || better);

        have_best_next  = have_best_reg || take;
        open_count_next = open_count_reg + CNT_W'(open_ok);
        best_key_next   = take ? key             : best_key_reg;
        best_size_next  = take ? item.dom_size   : best_size_reg;
        best_susp_next  = take ? item.susp_count : best_susp_reg;
        best_rank_next  = take ? open_count_reg[RANK_W-1:0] : best_rank_reg;
        best_min_next   = take ? item.dom_min    : best_min_reg;
        best_mid_next   = take ? item.dom_mid    : best_mid_reg;
        best_max_next   = take ? item.dom_max    : best_max_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg  <= 1'b0;
            open_count_reg <= '0;
        end else if (step) begin
            if (item.last_item) begin
                have_best_reg  <= 1'b0;
                open_count_reg <= '0;
            end else begin
                have_best_reg  <= have_best_next;
                open_count_reg <= open_count_next;
            end
        end
    end

    // payload only matters while have_best is set
    always_ff @(posedge aclk) begin
        if (step) begin
            best_key_reg  <= best_key_next;
            best_size_reg <= best_size_next;
            best_susp_reg <= best_susp_next;
            best_rank_reg <= best_rank_next;
            best_min_reg  <= best_min_next;
            best_mid_reg  <= best_mid_next;
            best_max_reg  <= best_max_next;
        end
    end

    assign best.have_best = have_best_next;
    assign best.best_min  = best_min_next;
    assign best.best_mid  = best_mid_next;
    assign best.best_max  = best_max_next;
    assign open_count     = open_count_next;
    assign best_rank      = best_rank_next;

endmodule

`default_nettype wire

// ----- rtl/fdbvs_result.sv -----
// ----------------------------------------------------------------------------
// fdbvs_result
// Value range selection, rank conversion and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdbvs_result import fdbvs_pkg::*; #(
    parameter int MAX_VARS = 1024,
    localparam int CNT_W  = $clog2(MAX_VARS + 1),
    localparam int RANK_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   fire,
    input  wire best_t                  best,
    input  wire logic [CNT_W-1:0]       open_count,
    input  wire logic [RANK_W-1:0]      best_rank,
    input  wire cfg_t                   cfg,
    output logic                        slot_free,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tuser
);

    localparam int DIFF_W = (CNT_W > SEL_BITS) ? CNT_W : SEL_BITS;
    localparam int PAD_W  = OUT_TDATA_W - SEL_BITS - 2 * VALUE_BITS - ALT_BITS;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic                   open_reg, open_next;

    logic [STRAT_BITS-1:0]  vs;
    logic [VALUE_BITS-1:0]  val_lo, val_hi, mid_inc;
    logic [DIFF_W-1:0]      diff;
    logic [SEL_BITS-1:0]    sel_index;
    logic [ALT_BITS-1:0]    alternatives;

    always_comb begin
        vs = cfg.val_strategy;
        if (cfg.assign_mode && (vs == VAL_SPLIT_LO || vs == VAL_SPLIT_HI)) begin
            vs = VAL_MIN;
        end
        // upper split saturates at the top value
        mid_inc = (&best.best_mid) ? best.best_mid : best.best_mid + VALUE_BITS'(1);

        case (vs)
            VAL_MID: begin
                val_lo = best.best_mid;
                val_hi = best.best_mid;
            end
            VAL_MAX: begin
                val_lo = best.best_max;
                val_hi = best.best_max;
            end
            VAL_SPLIT_LO: begin
                val_lo = '0;
                val_hi = best.best_mid;
            end
            VAL_SPLIT_HI: begin
                val_lo = mid_inc;
                val_hi = cfg.domain_sup;
            end
            default: begin
                val_lo = best.best_min;
                val_hi = best.best_min;
            end
        endcase

        // scan runs from the highest index, so flip the rank
        diff      = DIFF_W'(open_count) - DIFF_W'(best_rank) - DIFF_W'(1);
        sel_index = diff[SEL_BITS-1:0];
        alternatives = cfg.assign_mode ? ALT_ONE : ALT_TWO;

        if (!best.have_best) begin
            sel_index    = '0;
            val_lo       = '0;
            val_hi       = '0;
            alternatives = ALT_ONE;
        end
    end

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    assign data_next  = {{PAD_W{1'b0}}, alternatives, val_hi, val_lo, sel_index};
    assign open_next  = best.have_best;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            data_reg <= data_next;
            open_reg <= open_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = open_reg;

endmodule

`default_nettype wire

// ----- rtl/fd_branching_variable_selector.sv -----
// ----------------------------------------------------------------------------
// fd_branching_variable_selector
// First-fail branching variable and value selector over a descriptor stream.
// ----------------------------------------------------------------------------
// Usage:
//   Descriptors enter on the s_ channel in scan order, highest original index
//   first, one transfer per variable; s_tlast marks the last of a vector.
//   Determined descriptors (s_tuser high) are skipped. Once a vector holds
//   MAX_VARS open descriptors, further open ones are ignored.
//   After the last transfer of a vector one result leaves on the m_ channel:
//   m_tuser tells whether any open variable was seen, m_tdata carries the
//   chosen rank, the value or value range and the branch count.
//   A descriptor sits in the input register and is folded into the running
//   best as it leaves it; the result of a vector is loaded into the output
//   register as the last descriptor leaves the input register. Throughput is
//   one descriptor per cycle while no last descriptor is held, set by the
//   single compare-and-update of the running best.
//   When the receiver stalls, the result waits in the output register and
//   ordinary descriptors keep flowing; only a second last descriptor is held
//   in the input register until the pending result is taken.
//   Reset (aresetn low, synchronous) clears both channels, the running best
//   and loads the register defaults. Registers are to be written over APB
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fd_branching_variable_selector import fdbvs_pkg::*; #(
    parameter int MAX_VARS = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // descriptor channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata from bit 0: dom_size, dom_width, dom_min, dom_max, dom_mid,
    // susp_count, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: is_determined
    input  wire logic                   s_tuser,
    input  wire logic                   s_tlast,
    // result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata from bit 0: sel_index, val_lo, val_hi, alternatives, zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // m_tuser: any_open
    output logic                        m_tuser,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic      [PDATA_W-1:0]     prdata,
    output logic                        pready
);

    localparam int CNT_W  = $clog2(MAX_VARS + 1);
    localparam int RANK_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

    cfg_t              cfg;
    item_t             s_item;
    item_t             item_reg;
    logic              in_valid_reg, in_valid_next;
    logic              advance;
    logic              slot_free;
    best_t             best;
    logic [CNT_W-1:0]  open_count;
    logic [RANK_W-1:0] best_rank;

    // unpack the descriptor transfer
    assign s_item.is_determined = s_tuser;
    assign s_item.dom_size      = s_tdata[VALUE_BITS-1:0];
    assign s_item.dom_width     = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign s_item.dom_min       = s_tdata[3*VALUE_BITS-1:2*VALUE_BITS];
    assign s_item.dom_max       = s_tdata[4*VALUE_BITS-1:3*VALUE_BITS];
    assign s_item.dom_mid       = s_tdata[5*VALUE_BITS-1:4*VALUE_BITS];
    assign s_item.susp_count    = s_tdata[5*VALUE_BITS+SUSP_BITS-1:5*VALUE_BITS];
    assign s_item.last_item     = s_tlast;

    // a held descriptor moves on unless it would produce a result while the
    // output register is still occupied
    assign advance  = in_valid_reg && (!item_reg.last_item || slot_free);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 :
                           (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    fdbvs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdbvs_accum #(
        .MAX_VARS (MAX_VARS)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (item_reg),
        .cfg        (cfg),
        .best       (best),
        .open_count (open_count),
        .best_rank  (best_rank)
    );

    fdbvs_result #(
        .MAX_VARS (MAX_VARS)
    ) u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance && item_reg.last_item),
        .best       (best),
        .open_count (open_count),
        .best_rank  (best_rank),
        .cfg        (cfg),
        .slot_free  (slot_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/fdbvs_checker.sv -----
// ----------------------------------------------------------------------------
// fdbvs_checker
// Port-level checks of the selector's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdbvs_checker import fdbvs_pkg::*; (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   m_tuser
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // empty vector: zero rank and range, single alternative
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            m_tdata[63:0] == 64'd0 && m_tdata[65:64] == ALT_ONE)
        else $error("bad result for a vector with no open variable");

    // branch count is one or two, padding stays zero
    a_alt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:64] == ALT_ONE || m_tdata[65:64] == ALT_TWO) &&
            m_tdata[OUT_TDATA_W-1:66] == '0)
        else $error("bad alternatives or padding");

endmodule

bind fd_branching_variable_selector fdbvs_checker u_fdbvs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- verif/fd_branching_variable_selector_tb.sv -----
// ----------------------------------------------------------------------------
// fd_branching_variable_selector_tb
// Self-checking bench for the first-fail variable and value selector.
// ----------------------------------------------------------------------------
// A directed list of descriptors and register settings comes first. It covers
// empty vectors, extreme field values, every variable and value strategy,
// the unknown codes, assign mode, saturation of the upper split and a
// strategy change in the middle of a vector. Random vectors follow over
// several register settings and idle patterns. One of them is long enough to
// hit the open-variable cap. A behavioral model of the selection predicts
// every result, and each result transfer is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fd_branching_variable_selector_tb;
    import fdbvs_pkg::*;

    localparam int MAX_OPEN      = 1024;     // matches the default MAX_VARS
    localparam int RANDOM_ITEMS  = 1440;
    localparam int MIN_RESULTS   = 48;
    localparam int LONG_VECTOR   = MAX_OPEN + 8;
    localparam int QUIET_LIMIT   = 4000;     // cycles with no transfer at all
    localparam logic [VALUE_BITS-1:0] VMAX = '1;

    // one result of the selector
    typedef struct packed {
        logic                  any_open;
        logic [SEL_BITS-1:0]   sel_index;
        logic [VALUE_BITS-1:0] val_lo;
        logic [VALUE_BITS-1:0] val_hi;
        logic [ALT_BITS-1:0]   alternatives;
    } decision_t;

    typedef enum int {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        item_t     desc;
        bit        typed;        // expectation written in by hand
        decision_t want;
        cfg_t      cfg;
    } row_t;

    // ------------------------------------------------------------------------
    // clock, reset, DUT signals
    // ------------------------------------------------------------------------
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    always #6 aclk = ~aclk;

    fd_branching_variable_selector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    decision_t expected_decisions[$];
    row_t      directed_rows[$];
    int        mismatch_count  = 0;
    int        results_seen    = 0;
    int        quiet_cycles    = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;

    // shadow of the registers and of the running best
    cfg_t                  cfg_shadow;
    bit                    run_have_best;
    logic [VALUE_BITS-1:0] run_key;
    logic [VALUE_BITS-1:0] run_size;
    logic [SUSP_BITS-1:0]  run_susp;
    int unsigned           run_rank;
    int unsigned           open_seen;
    logic [VALUE_BITS-1:0] run_min;
    logic [VALUE_BITS-1:0] run_mid;
    logic [VALUE_BITS-1:0] run_max;

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    function automatic void clear_running_best();
        run_have_best = 1'b0;
        run_key       = '0;
        run_size      = '0;
        run_susp      = '0;
        run_rank      = 0;
        open_seen     = 0;
        run_min       = '0;
        run_mid       = '0;
        run_max       = '0;
    endfunction

    // Fold one accepted descriptor into the running best; on the last one of
    // a vector, queue the expected decision and start over.
    function automatic void fold_descriptor(input item_t d);
        logic [STRAT_BITS-1:0] strat;
        logic [STRAT_BITS-1:0] vs;
        logic [VALUE_BITS-1:0] key;
        bit                    take;
        decision_t             dec;
        strat = cfg_shadow.assign_mode ? VAR_NAIVE : cfg_shadow.var_strategy;
        if (!d.is_determined && open_seen < MAX_OPEN) begin
            case (strat)
                VAR_SIZE, VAR_MOST: key = d.dom_size;
                VAR_WIDTH:          key = d.dom_width;
                VAR_MIN:            key = d.dom_min;
                VAR_MAX:            key = d.dom_max;
                default:            key = '0;
            endcase
            if (!run_have_best) begin
                take = 1'b1;
            end else begin
                case (strat)
                    VAR_SIZE, VAR_WIDTH, VAR_MIN: take = key < run_key;
                    VAR_MAX:  take = key > run_key;
                    VAR_MOST: take = d.susp_count > run_susp ||
                                     (d.susp_count == run_susp && d.dom_size < run_size);
                    default:  take = 1'b0;   // naive and unknown codes keep the first
                endcase
            end
            if (take) begin
                run_have_best = 1'b1;
                run_key       = key;
                run_size      = d.dom_size;
                run_susp      = d.susp_count;
                run_rank      = open_seen;
                run_min       = d.dom_min;
                run_mid       = d.dom_mid;
                run_max       = d.dom_max;
            end
            open_seen++;
        end
        if (!d.last_item)
            return;
        if (run_have_best) begin
            vs = cfg_shadow.val_strategy;
            // assign mode never splits
            if (cfg_shadow.assign_mode && vs > VAL_MAX)
                vs = VAL_MIN;
            case (vs)
                VAL_MID: begin
                    dec.val_lo = run_mid;
                    dec.val_hi = run_mid;
                end
                VAL_MAX: begin
                    dec.val_lo = run_max;
                    dec.val_hi = run_max;
                end
                VAL_SPLIT_LO: begin
                    dec.val_lo = '0;
                    dec.val_hi = run_mid;
                end
                VAL_SPLIT_HI: begin
                    // mid+1 saturates at the top value
                    dec.val_lo = (run_mid == VMAX) ? VMAX : run_mid + 1'b1;
                    dec.val_hi = cfg_shadow.domain_sup;
                end
                default: begin
                    dec.val_lo = run_min;
                    dec.val_hi = run_min;
                end
            endcase
            dec.any_open     = 1'b1;
            dec.sel_index    = SEL_BITS'(open_seen - 1 - run_rank);
            dec.alternatives = cfg_shadow.assign_mode ? ALT_ONE : ALT_TWO;
        end else begin
            dec = '{1'b0, '0, '0, '0, ALT_ONE};
        end
        expected_decisions.push_back(dec);
        clear_running_best();
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic item_t mk_item(input bit det, input int unsigned sz,
                                      input int unsigned wd, input int unsigned mn,
                                      input int unsigned mx, input int unsigned md,
                                      input int unsigned sp, input bit last);
        item_t d;
        d.is_determined = det;
        d.dom_size      = VALUE_BITS'(sz);
        d.dom_width     = VALUE_BITS'(wd);
        d.dom_min       = VALUE_BITS'(mn);
        d.dom_max       = VALUE_BITS'(mx);
        d.dom_mid       = VALUE_BITS'(md);
        d.susp_count    = SUSP_BITS'(sp);
        d.last_item     = last;
        return d;
    endfunction

    function automatic row_t item_row(input item_t d, input bit typed, input decision_t want);
        row_t r;
        r.kind  = ROW_ITEM;
        r.desc  = d;
        r.typed = typed;
        r.want  = want;
        r.cfg   = '0;
        return r;
    endfunction

    function automatic row_t cfg_row(input cfg_t c);
        row_t r;
        r.kind  = ROW_CFG;
        r.desc  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        r.cfg   = c;
        return r;
    endfunction

    // extremes and small values show up often, so ties and limits get hit
    function automatic logic [VALUE_BITS-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VMAX;
            2, 3:    return VALUE_BITS'($urandom_range(15));
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic item_t rand_descriptor(input int det_pct, input bit last);
        item_t d;
        d.is_determined = ($urandom_range(99) < det_pct);
        d.dom_size      = rand_value();
        d.dom_width     = rand_value();
        d.dom_min       = rand_value();
        d.dom_max       = rand_value();
        d.dom_mid       = rand_value();
        case ($urandom_range(5))
            0:       d.susp_count = '0;
            1:       d.susp_count = '1;
            2, 3:    d.susp_count = SUSP_BITS'($urandom_range(3));
            default: d.susp_count = SUSP_BITS'($urandom);
        endcase
        d.last_item = last;
        return d;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.var_strategy = STRAT_BITS'($urandom_range(7));
        c.val_strategy = STRAT_BITS'($urandom_range(7));
        c.assign_mode  = ($urandom_range(3) == 0);
        c.domain_sup   = rand_value();
        return c;
    endfunction

    // One descriptor transfer, with random idle cycles ahead of it. s_tvalid
    // stays high on return so back-to-back items need no extra NBA.
    task automatic send_descriptor(input item_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, d.susp_count, d.dom_mid, d.dom_max, d.dom_min,
                     d.dom_width, d.dom_size};
        s_tuser  <= d.is_determined;
        s_tlast  <= d.last_item;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        fold_descriptor(d);
    endtask

    // Stop sending, wait for every result, then let the pipeline empty out (a
    // non-last descriptor gives no result but still passes the input register).
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_decisions.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write, then read back the same register.
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);                // register takes the write here
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== value)
            log_mismatch($sformatf("reg %s read 0x%0h, wrote 0x%0h", idx.name(),
                                   prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        write_reg(REG_VAR_STRAT,  PDATA_W'(c.var_strategy));
        write_reg(REG_VAL_STRAT,  PDATA_W'(c.val_strategy));
        write_reg(REG_ASSIGN,     PDATA_W'(c.assign_mode));
        write_reg(REG_DOMAIN_SUP, PDATA_W'(c.domain_sup));
        cfg_shadow = c;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls on the result channel
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checker and activity counter for the watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        decision_t got;
        decision_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready) begin
                got.any_open     = m_tuser;
                got.sel_index    = m_tdata[SEL_BITS-1:0];
                got.val_lo       = m_tdata[SEL_BITS +: VALUE_BITS];
                got.val_hi       = m_tdata[SEL_BITS+VALUE_BITS +: VALUE_BITS];
                got.alternatives = m_tdata[SEL_BITS+2*VALUE_BITS +: ALT_BITS];
                results_seen++;
                if (expected_decisions.size() == 0) begin
                    log_mismatch($sformatf("unexpected result open=%0b idx=%0d lo=%0d hi=%0d alt=%0d",
                                           got.any_open, got.sel_index, got.val_lo,
                                           got.val_hi, got.alternatives));
                end else begin
                    want = expected_decisions.pop_front();
                    if (got !== want)
                        log_mismatch($sformatf({"open exp %0b got %0b, idx exp %0d got %0d, ",
                                                "lo exp %0d got %0d, hi exp %0d got %0d, ",
                                                "alt exp %0d got %0d"},
                                               want.any_open, got.any_open,
                                               want.sel_index, got.sel_index,
                                               want.val_lo, got.val_lo,
                                               want.val_hi, got.val_hi,
                                               want.alternatives, got.alternatives));
                end
            end
        end
    end

    // watchdog: no transfer on any port for too long means a hang
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // directed list
    // ------------------------------------------------------------------------
    initial begin : build_directed
        // reset setup: naive variable, minimum value, distributing
        // empty vector: one determined descriptor
        directed_rows.push_back(item_row(mk_item(1, 0, 0, 0, 0, 0, 0, 1), 1,
                                         '{1'b0, '0, '0, '0, ALT_ONE}));
        // all fields at their top value
        directed_rows.push_back(item_row(mk_item(0, VMAX, VMAX, VMAX, VMAX, VMAX,
                                                 16'hFFFF, 1), 1,
                                         '{1'b1, '0, VMAX, VMAX, ALT_TWO}));
        // all fields zero
        directed_rows.push_back(item_row(mk_item(0, 0, 0, 0, 0, 0, 0, 1), 1,
                                         '{1'b1, '0, '0, '0, ALT_TWO}));
        // naive keeps the first scanned; it is the last open in original order
        directed_rows.push_back(item_row(mk_item(0, 4, 4, 5, 20, 12, 3, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 2, 9, 9, 30, 19, 1, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(1, 1, 1, 1, 1, 1, 0, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 7, 2, 1, 40, 20, 8, 1), 1,
                                         '{1'b1, 10'd2, 27'd5, 27'd5, ALT_TWO}));
        // smallest size, tie keeps the earlier entry
        directed_rows.push_back(cfg_row('{VAR_SIZE, VAL_MID, 1'b0, DOMAIN_SUP_RST}));
        directed_rows.push_back(item_row(mk_item(0, 10, 1, 1, 90, 100, 0, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 3, 2, 2, 80, 30, 0, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 3, 3, 3, 70, 31, 0, 1), 0, '0));
        // smallest width, maximum value
        directed_rows.push_back(cfg_row('{VAR_WIDTH, VAL_MAX, 1'b0, DOMAIN_SUP_RST}));
        directed_rows.push_back(item_row(mk_item(0, 5, 8, 2, 50, 9, 1, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 5, 6, 3, 60, 9, 1, 1), 0, '0));
        // smallest min, lower split
        directed_rows.push_back(cfg_row('{VAR_MIN, VAL_SPLIT_LO, 1'b0, DOMAIN_SUP_RST}));
        directed_rows.push_back(item_row(mk_item(0, 5, 8, 2, 50, 9, 1, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 5, 6, 3, 60, 11, 1, 1), 0, '0));
        // largest max, upper split with mid at the top value saturates
        directed_rows.push_back(cfg_row('{VAR_MAX, VAL_SPLIT_HI, 1'b0, VMAX}));
        directed_rows.push_back(item_row(mk_item(0, 1, 1, 0, VMAX, VMAX, 0, 1), 1,
                                         '{1'b1, '0, VMAX, VMAX, ALT_TWO}));
        // most constrained with size tie break, unknown value code acts as min
        directed_rows.push_back(cfg_row('{VAR_MOST, 3'd7, 1'b0, 27'd0}));
        directed_rows.push_back(item_row(mk_item(0, 9, 1, 21, 40, 30, 4, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 5, 1, 22, 40, 30, 4, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 5, 1, 23, 40, 30, 4, 1), 0, '0));
        // assign mode: unknown variable code, split falls back to one min value
        directed_rows.push_back(cfg_row('{3'd7, VAL_SPLIT_HI, 1'b1, DOMAIN_SUP_RST}));
        directed_rows.push_back(item_row(mk_item(0, 1, 1, 11, 40, 20, 0, 0), 0, '0));
        directed_rows.push_back(item_row(mk_item(0, 1, 1, 3, 40, 20, 9, 1), 1,
                                         '{1'b1, 10'd1, 27'd11, 27'd11, ALT_ONE}));
        // strategy switched mid-vector: max compares against the stored size
        directed_rows.push_back(cfg_row('{VAR_SIZE, VAL_SPLIT_HI, 1'b0, 27'd1000}));
        directed_rows.push_back(item_row(mk_item(0, 50, 1, 1, 70, 40, 0, 0), 0, '0));
        directed_rows.push_back(cfg_row('{VAR_MAX, VAL_SPLIT_HI, 1'b0, 27'd1000}));
        directed_rows.push_back(item_row(mk_item(0, 60, 1, 2, 80, 45, 0, 1), 0, '0));
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int random_items;
        int results_base;
        int phase;
        int phase_items;
        int vec_len;
        cfg_shadow = '{VAR_NAIVE, VAL_MIN, 1'b0, DOMAIN_SUP_RST};
        clear_running_best();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                apply_cfg(directed_rows[i].cfg);
            end else begin
                send_descriptor(directed_rows[i].desc);
                if (directed_rows[i].typed) begin
                    // the hand-written value replaces the predicted one
                    void'(expected_decisions.pop_back());
                    expected_decisions.push_back(directed_rows[i].want);
                end
            end
        end

        // one vector with more open variables than the block can count
        settle();
        apply_cfg(rand_cfg());
        for (int i = 0; i < LONG_VECTOR; i++)
            send_descriptor(rand_descriptor(0, i == LONG_VECTOR - 1));
        random_items = LONG_VECTOR;
        results_base = results_seen;

        // short random vectors, new registers and idle pattern per phase
        phase = 0;
        while (random_items < RANDOM_ITEMS || results_seen - results_base < MIN_RESULTS) begin
            settle();
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            apply_cfg(rand_cfg());
            phase_items = 0;
            while (phase_items < 60) begin
                vec_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 10);
                for (int i = 0; i < vec_len; i++)
                    send_descriptor(rand_descriptor(25, i == vec_len - 1));
                phase_items += vec_len;
            end
            // sometimes leave a vector open across the register change
            if ($urandom_range(1)) begin
                vec_len = $urandom_range(1, 4);
                for (int i = 0; i < vec_len; i++)
                    send_descriptor(rand_descriptor(25, 1'b0));
                phase_items += vec_len;
            end
            random_items += phase_items;
            phase++;
        end

        // close any open vector, then drain
        send_descriptor(rand_descriptor(25, 1'b1));
        settle();
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && expected_decisions.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
